[rtl/core/asidl_pkg.sv]
`default_nettype none

package asidl_pkg;

    // Request codes carried in the opcode field; code 3 behaves as a lookup.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Field widths fixed by the stream format.
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned IN_KEY_W = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 16;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_MOVE,
        S_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic rd_issue;
        logic found;
        logic resolve;
        logic append;
        logic remove;
        logic move_wr;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic idx_lt_count;
        logic cmp_pending;
        logic do_append;
        logic do_remove;
    } dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/array_set_insert_delete_lookup.sv]
// Requests are handled one at a time: the next word is accepted only once the result of the
// last request has been registered. A hit ends the scan at the matching entry, a miss reads
// every held key, and a delete that removes an entry adds a step that moves the last entry
// into the freed slot. The linear scan reads one stored key per cycle from the key memory.
// Reset (aresetn low, synchronous) empties the set and clears all handshake state.
`default_nettype none

module array_set_insert_delete_lookup #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // opcode [1:0], key [33:2], zero [39:34]
    input  wire logic [asidl_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status [1:0], present [2], entry_count [9:3], zero [15:10]
    output logic      [asidl_pkg::M_DATA_W-1:0]  m_tdata
);

    import asidl_pkg::*;

    dp_cmd_t             cmd;
    dp_sts_t             sts;
    logic [STATUS_W-1:0] out_status;
    logic                out_present;
    logic [COUNT_W-1:0]  out_count;

    // Sequencer.
    asidl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Key store, scan compare and result registers.
    asidl_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_opcode   (s_tdata[OPCODE_W-1:0]),
        .in_key      (s_tdata[OPCODE_W+IN_KEY_W-1:OPCODE_W]),
        .cmd         (cmd),
        .sts         (sts),
        .out_status  (out_status),
        .out_present (out_present),
        .out_count   (out_count)
    );

    // Pack the result word.
    assign m_tdata = {{(M_DATA_W - STATUS_W - 1 - COUNT_W){1'b0}},
                      out_count, out_present, out_status};

endmodule

`default_nettype wire

[rtl/core/asidl_ram.sv]
`default_nettype none

module asidl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/asidl_ctrl.sv]
`default_nettype none

module asidl_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output asidl_pkg::dp_cmd_t      cmd,
    input  wire asidl_pkg::dp_sts_t sts
);

    import asidl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.hit) begin
                    cmd.found  = 1'b1;
                    state_next = S_RESOLVE;
                end else if (!sts.cmp_pending && !sts.idx_lt_count) begin
                    state_next = S_RESOLVE;
                end else begin
                    cmd.rd_issue = sts.idx_lt_count;
                end
            end
            S_RESOLVE: begin
                cmd.resolve = 1'b1;
                if (sts.do_append) begin
                    cmd.append = 1'b1;
                    state_next = S_FINISH;
                end else if (sts.do_remove) begin
                    cmd.remove = 1'b1;
                    state_next = S_MOVE;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_MOVE: begin
                // The last entry has been read; write it into the freed slot.
                cmd.move_wr = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/asidl_dp.sv]
`default_nettype none

module asidl_dp #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [asidl_pkg::OPCODE_W-1:0]  in_opcode,
    input  wire logic [asidl_pkg::IN_KEY_W-1:0]  in_key,
    input  wire asidl_pkg::dp_cmd_t              cmd,
    output asidl_pkg::dp_sts_t                   sts,
    output logic      [asidl_pkg::STATUS_W-1:0]  out_status,
    output logic                                 out_present,
    output logic      [asidl_pkg::COUNT_W-1:0]   out_count
);

    import asidl_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = CW + COUNT_W;

    logic [OPCODE_W-1:0]  op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        idx_reg;
    logic [AW-1:0]        cmp_idx_reg;
    logic                 cmp_vld_reg;
    logic [AW-1:0]        slot_reg;
    logic                 held_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_present_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                 full;
    logic [EW-1:0]        count_ext;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    // Key storage.
    asidl_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read during the scan walks the index; a removal reads the last entry.
    assign ram_raddr = cmd.remove ? AW'(count_reg - CW'(1)) : idx_reg[AW-1:0];

    // Writes: append at the count, or move the last entry into the freed slot.
    assign ram_we    = cmd.append || cmd.move_wr;
    assign ram_waddr = cmd.append ? count_reg[AW-1:0] : slot_reg;
    assign ram_wdata = cmd.append ? key_reg : ram_rdata;

    assign full = (count_reg == CW'(DEPTH));

    // Status toward the controller.
    assign sts.hit          = cmp_vld_reg && (ram_rdata == key_reg);
    assign sts.idx_lt_count = (idx_reg < count_reg);
    assign sts.cmp_pending  = cmp_vld_reg;
    assign sts.do_append    = (op_reg == OP_INSERT) && !held_reg && !full;
    assign sts.do_remove    = (op_reg == OP_DELETE) && held_reg;

    // Result code of the request once the search is over.
    always_comb begin
        case (op_reg)
            OP_INSERT: begin
                if (held_reg) begin
                    status_next = ST_PRESENT;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_DONE;
                end
            end
            OP_DELETE, OP_LOOKUP: begin
                status_next = held_reg ? ST_DONE : ST_NOT_FOUND;
            end
            default: begin
                status_next = held_reg ? ST_DONE : ST_NOT_FOUND;
            end
        endcase
    end

    // Count update.
    always_comb begin
        count_next = count_reg;
        if (cmd.append) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Control registers: fill count and the compare pipeline flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            cmp_vld_reg <= cmd.rd_issue;
        end
    end

    // Request, scan and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg   <= in_opcode;
            key_reg  <= KEY_WIDTH'(in_key);
            idx_reg  <= '0;
            held_reg <= 1'b0;
        end
        if (cmd.rd_issue) begin
            idx_reg     <= idx_reg + CW'(1);
            cmp_idx_reg <= idx_reg[AW-1:0];
        end
        if (cmd.found) begin
            held_reg <= 1'b1;
            slot_reg <= cmp_idx_reg;
        end
        if (cmd.resolve) begin
            status_reg <= status_next;
        end
        if (cmd.load_out) begin
            out_status_reg  <= status_reg;
            out_present_reg <= held_reg;
            out_count_reg   <= count_ext[COUNT_W-1:0];
        end
    end

    assign count_ext   = EW'(count_reg);
    assign out_status  = out_status_reg;
    assign out_present = out_present_reg;
    assign out_count   = out_count_reg;

endmodule

`default_nettype wire
